### rtl/abmp_pkg.sv
// Shared types, constants and header builder for the ARGB to BMP v4 encoder.
// Used by the top level and the divider; no dependencies.

package abmp_pkg;

  // Default upper bound on image width and height
  localparam int MAX_DIM_DEF = 4096;
  // Width of the dimension configuration registers
  localparam int DIM_W       = 13;
  localparam int CFG_IDX_W   = 2;

  // Header geometry: 30 full words then one word with 2 valid bytes
  localparam int HDR_WORDS   = 31;
  localparam int HDR_BYTES   = 122;
  localparam int DIB_BYTES   = 108;
  localparam int HDR_BITS    = 4 * 8 * 31;

  localparam logic [2:0] BC_FULL = 3'd4;
  localparam logic [2:0] BC_TAIL = 3'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREMUL = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_DIV,
    ST_PIX
  } state_t;

  // Request into the shared divider
  typedef struct packed {
    logic       start;
    logic [7:0] numer;
    logic [7:0] denom;
  } div_req_t;

  // Response from the shared divider
  typedef struct packed {
    logic       done;
    logic [7:0] quot;
  } div_rsp_t;

  // Build header word idx (little-endian bytes) from the image geometry
  function automatic logic [31:0] hdr_word(input logic [4:0]       idx,
                                           input logic [DIM_W-1:0] w,
                                           input logic [DIM_W-1:0] h,
                                           input logic [31:0]      datasz);
    logic [HDR_BITS-1:0] hb;
    logic [9:0]          bit_pos;
    hb = '0;
    hb[7:0]        = 8'h42;
    hb[15:8]       = 8'h4d;
    hb[2*8 +: 32]  = 32'(HDR_BYTES) + datasz;
    hb[10*8 +: 32] = 32'(HDR_BYTES);
    hb[14*8 +: 32] = 32'(DIB_BYTES);
    hb[18*8 +: 32] = {{(32-DIM_W){1'b0}}, w};
    hb[22*8 +: 32] = 32'd0 - {{(32-DIM_W){1'b0}}, h};
    hb[26*8 +: 32] = 32'h0020_0001;
    hb[30*8 +: 32] = 32'd3;
    hb[34*8 +: 32] = datasz;
    hb[54*8 +: 32] = 32'h0000_00ff;
    hb[58*8 +: 32] = 32'h0000_ff00;
    hb[62*8 +: 32] = 32'h00ff_0000;
    hb[66*8 +: 32] = 32'hff00_0000;
    bit_pos = {idx, 5'b00000};
    return hb[bit_pos +: 32];
  endfunction

endpackage

### rtl/argb_to_bmp_v4_stream_encoder.sv
// ARGB pixel stream to BMP (BITMAPV4, 32 bpp, bitfields) byte stream encoder.
// Depends on abmp_pkg and abmp_div (shared channel divider).
//
// Usage:
//   Configure image width, height and premultiplied mode on the cfg_ port
//   while the block is idle. Feed ARGB pixels on in_; little-endian output
//   words leave on out_. Before the first pixel of each image the block emits
//   31 header words (the last one holds 2 valid bytes, flagged in tdata).
//   out_tuser marks header words, out_tlast marks the pixel word that ends
//   each input transaction, and a tdata bit marks the image's last pixel.
// Sequence:
//   A pixel with no un-premultiply is accepted, then loaded into the output.
//   The first pixel of an image sends the header first, one word per load.
//   An un-premultiplied pixel runs R, G and B through one shared divider,
//   each channel in turn (operand load, 4 iterations of 2 quotient bits,
//   result). A new pixel is not accepted until the last one is loaded.
// Reset: dimensions return to 1x1, premultiplied mode off, the pixel count to
// zero so a header leads the next pixel. A stalled receiver holds the output
// register and the header and pixel loads, not the divide; a new pixel is
// still accepted while the final word of the previous pixel waits.

module argb_to_bmp_v4_stream_encoder import abmp_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input pixels
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // [31:0] pixel_argb
  // Output words
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,  // [31:0] out_word, [34:32] byte_count,
                                           // [35] end_of_image, [39:36] zero
  output logic                 out_tuser,  // [0] is_header
  output logic                 out_tlast,  // last_of_run
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  // Largest dimension that the 13-bit registers can reach under MAX_DIM
  localparam longint DIM_CAP   = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
  localparam int     CNT_W     = $clog2(DIM_CAP * DIM_CAP + 1);
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(DIM_CAP);
  localparam logic [4:0] HDR_LAST = 5'(HDR_WORDS - 1);

  // Channel codes of the divider sequence
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0] width_r, height_r;
  logic             premul_r;
  logic [CNT_W-1:0] pixels_done_r, pixels_done_nxt;
  logic [CNT_W-1:0] npix_r;
  logic [31:0]      pix_r;
  logic             need_div_r;
  logic [4:0]       hidx_r;
  logic [1:0]       ch_r;
  logic             issued_r;

  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_bc_r;
  logic        out_hdr_r;
  logic        out_last_r;
  logic        out_eoi_r;

  logic [DIM_W-1:0] w_c, h_c;
  logic             in_acc;
  logic             out_free;
  logic             need_div;
  logic             load_hdr;
  logic             load_pix;
  logic             eoi;
  logic [31:0]      datasz;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  abmp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Clamp dimensions into 1..MAX_DIM
  always_comb begin
    w_c = (width_r == '0) ? DIM_W'(1) : ((width_r > DIM_MAX) ? DIM_MAX : width_r);
    h_c = (height_r == '0) ? DIM_W'(1) : ((height_r > DIM_MAX) ? DIM_MAX : height_r);
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign need_div  = premul_r && (in_tdata[31:24] != 8'hff) && (in_tdata[31:24] != 8'h00);
  assign datasz    = 32'({npix_r, 2'b00});
  assign eoi       = ({1'b0, pixels_done_r} + {{CNT_W{1'b0}}, 1'b1}) >= {1'b0, npix_r};
  assign pixels_done_nxt = eoi ? '0 : pixels_done_r + CNT_W'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (pixels_done_r == '0) state_nxt = ST_HDR;
          else if (need_div)       state_nxt = ST_DIV;
          else                     state_nxt = ST_PIX;
        end
      end
      ST_HDR: begin
        if (out_free && hidx_r == HDR_LAST) begin
          state_nxt = need_div_r ? ST_DIV : ST_PIX;
        end
      end
      ST_DIV: begin
        if (div_rsp.done && ch_r == CH_BLUE) state_nxt = ST_PIX;
      end
      ST_PIX: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    load_hdr      = (state_r == ST_HDR) && out_free;
    load_pix      = (state_r == ST_PIX) && out_free;
    div_req.start = (state_r == ST_DIV) && !issued_r;
    div_req.denom = pix_r[31:24];
    case (ch_r)
      CH_RED:   div_req.numer = pix_r[23:16];
      CH_GREEN: div_req.numer = pix_r[15:8];
      default:  div_req.numer = pix_r[7:0];
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      premul_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_PREMUL: premul_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pixels_done_r <= '0;
      hidx_r        <= '0;
      ch_r          <= CH_RED;
      issued_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        hidx_r   <= '0;
        ch_r     <= CH_RED;
        issued_r <= 1'b0;
      end
      if (load_hdr) hidx_r <= hidx_r + 5'd1;
      if (div_req.start) issued_r <= 1'b1;
      if (div_rsp.done) begin
        issued_r <= 1'b0;
        ch_r     <= ch_r + 2'd1;
      end
      if (load_pix) pixels_done_r <= pixels_done_nxt;
      // Hold the output word until taken
      if (load_hdr || load_pix) out_valid_r <= 1'b1;
      else if (out_tready)      out_valid_r <= 1'b0;
    end
  end

  // Pixel, pixel count and output payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      npix_r     <= CNT_W'({{DIM_W{1'b0}}, w_c} * {{DIM_W{1'b0}}, h_c});
      need_div_r <= need_div;
      // Alpha of zero in premultiplied mode drops the color bytes
      if (premul_r && in_tdata[31:24] == 8'h00) pix_r <= {in_tdata[31:24], 24'h000000};
      else                                      pix_r <= in_tdata;
    end else if (div_rsp.done) begin
      case (ch_r)
        CH_RED:   pix_r[23:16] <= div_rsp.quot;
        CH_GREEN: pix_r[15:8]  <= div_rsp.quot;
        default:  pix_r[7:0]   <= div_rsp.quot;
      endcase
    end
    if (load_hdr) begin
      out_word_r <= hdr_word(hidx_r, w_c, h_c, datasz);
      out_bc_r   <= (hidx_r == HDR_LAST) ? BC_TAIL : BC_FULL;
      out_hdr_r  <= 1'b1;
      out_last_r <= 1'b0;
      out_eoi_r  <= 1'b0;
    end else if (load_pix) begin
      out_word_r <= {pix_r[31:24], pix_r[7:0], pix_r[15:8], pix_r[23:16]};
      out_bc_r   <= BC_FULL;
      out_hdr_r  <= 1'b0;
      out_last_r <= 1'b1;
      out_eoi_r  <= eoi;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_eoi_r, out_bc_r, out_word_r};
  assign out_tuser  = out_hdr_r;
  assign out_tlast  = out_last_r;

  // A pixel that opens an image goes through the header first
  a_hdr_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && pixels_done_r == '0 |=> state_r == ST_HDR)
    else $error("image start did not enter header state");

  // Divider results arrive only while the sequencer waits for them
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider result outside divide state");

  // The image's last pixel word leaves with the count rearmed
  a_eoi_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_eoi_r |-> pixels_done_r == '0)
    else $error("end of image without pixel count reset");

endmodule

### rtl/abmp_div.sv
// Shared iterative divider for un-premultiplying one color channel.
// Depends on abmp_pkg for the request and response structs.

module abmp_div import abmp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic       busy_r;
  logic       done_r;
  logic       ovf_r;
  logic [1:0] cnt_r;
  logic [7:0] rem_r;
  logic [7:0] lo_r;
  logic [7:0] q_r;
  logic [7:0] den_r;

  logic [15:0] numer;
  logic        ovf;
  logic [8:0]  s1;
  logic [8:0]  s2;

  // One restoring step: returns {quotient bit, new remainder}
  function automatic logic [8:0] div_step(input logic [7:0] rem,
                                          input logic       nb,
                                          input logic [7:0] d);
    logic [8:0] t;
    t = {rem, nb};
    if (t >= {1'b0, d}) begin
      return {1'b1, 8'(t - {1'b0, d})};
    end else begin
      return {1'b0, t[7:0]};
    end
  endfunction

  // Form c*255 + a/2 and flag quotients that clamp to 255
  always_comb begin
    numer = {req.numer, 8'h00} - {8'h00, req.numer} + {9'h000, req.denom[7:1]};
    ovf   = numer >= {req.denom, 8'h00};
  end

  // Two quotient bits per cycle
  always_comb begin
    s1 = div_step(rem_r, lo_r[7], den_r);
    s2 = div_step(s1[7:0], lo_r[6], den_r);
  end

  // Control: four iterations after start, then a done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then shift in dividend bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= numer[15:8];
      lo_r  <= numer[7:0];
      den_r <= req.denom;
      ovf_r <= ovf;
    end else if (busy_r) begin
      rem_r <= s2[7:0];
      lo_r  <= {lo_r[5:0], 2'b00};
      q_r   <= {q_r[5:0], s1[8], s2[8]};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = ovf_r ? 8'hff : q_r;

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for argb_to_bmp_v4_stream_encoder: drives ARGB pixel and config transactions,
// predicts the BMP header and pixel words per pixel, and checks every output word in order.
// Depends on abmp_pkg and the encoder RTL.

module tb_top;
  import abmp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped register index
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
  localparam int DRAIN_CYCLES = 40;
  localparam int PIXEL_TARGET = 230;
  localparam int MAX_REPORTS  = 10;

  // One expected output word
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        hdr;
    logic        last;
    logic        eoi;
  } bmp_word_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  // Predictor state: configuration and image progress
  logic [DIM_W-1:0] img_w;
  logic [DIM_W-1:0] img_h;
  logic             premul_on;
  logic [23:0]      pix_done;
  logic [7:0]       hdr_bytes [0:123];

  bmp_word_t words_due [$];
  int        pixels_sent;
  int        mismatches;
  bit        quiet;

  argb_to_bmp_v4_stream_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: stall on about 10 percent of clocks unless in a quiet stretch
  always @(negedge clk) begin
    out_tready <= quiet || ($urandom_range(0, 99) >= 10);
  end

  // Zero and out-of-range dimensions collapse to the legal range
  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return 32'(v);
  endfunction

  function automatic void put_le32(input int off, input logic [31:0] v);
    int i;
    for (i = 0; i < 4; i++) hdr_bytes[off + i] = v[8*i +: 8];
  endfunction

  // Undo premultiplication with rounding, saturate at 255
  function automatic logic [7:0] unpremul_chan(input logic [7:0] c, input logic [7:0] a);
    int unsigned q;
    q = (c * 255 + a / 2) / a;
    return (q > 255) ? 8'hff : q[7:0];
  endfunction

  // Queue the words one accepted pixel produces: header when due, then the pixel
  function automatic void queue_pixel_words(input logic [31:0] px);
    int unsigned       w;
    int unsigned       h;
    int unsigned       done_cnt;
    longint unsigned   npix;
    logic [31:0]       datasz;
    logic [7:0]        a;
    logic [7:0]        r;
    logic [7:0]        g;
    logic [7:0]        b;
    bmp_word_t         due;
    int                i;
    w = clamp_dim(img_w);
    h = clamp_dim(img_h);
    npix = longint'(w) * longint'(h);
    a = px[31:24];
    r = px[23:16];
    g = px[15:8];
    b = px[7:0];
    if (pix_done == 0) begin
      datasz = 32'(npix * 4);
      for (i = 0; i < 124; i++) hdr_bytes[i] = 8'h00;
      hdr_bytes[0] = 8'h42;
      hdr_bytes[1] = 8'h4d;
      put_le32(2, 32'(HDR_BYTES) + datasz);
      put_le32(10, 32'(HDR_BYTES));
      put_le32(14, 32'(DIB_BYTES));
      put_le32(18, w);
      put_le32(22, 32'd0 - h);
      put_le32(26, 32'h0020_0001);
      put_le32(30, 32'd3);
      put_le32(34, datasz);
      put_le32(54, 32'h0000_00ff);
      put_le32(58, 32'h0000_ff00);
      put_le32(62, 32'h00ff_0000);
      put_le32(66, 32'hff00_0000);
      for (i = 0; i < HDR_WORDS; i++) begin
        due.word   = {hdr_bytes[4*i+3], hdr_bytes[4*i+2], hdr_bytes[4*i+1], hdr_bytes[4*i]};
        due.nbytes = (i < HDR_WORDS - 1) ? BC_FULL : BC_TAIL;
        due.hdr    = 1'b1;
        due.last   = 1'b0;
        due.eoi    = 1'b0;
        words_due.push_back(due);
      end
    end
    if (premul_on && a != ALPHA_OPAQUE) begin
      if (a == 0) begin
        r = 8'h00;
        g = 8'h00;
        b = 8'h00;
      end else begin
        r = unpremul_chan(r, a);
        g = unpremul_chan(g, a);
        b = unpremul_chan(b, a);
      end
    end
    done_cnt = 32'(pix_done);
    due.word   = {a, b, g, r};
    due.nbytes = BC_FULL;
    due.hdr    = 1'b0;
    due.last   = 1'b1;
    if (longint'(done_cnt) + 1 >= npix) begin
      due.eoi  = 1'b1;
      pix_done = '0;
    end else begin
      due.eoi  = 1'b0;
      pix_done = pix_done + 1'b1;
    end
    words_due.push_back(due);
  endfunction

  // Pixel mix: opaque, clear, tiny alphas, properly premultiplied or overdriven colors
  function automatic logic [31:0] random_argb();
    logic [7:0]  a;
    logic [23:0] rgb;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) a = ALPHA_OPAQUE;
    else if (pick < 35) a = 8'h00;
    else if (pick < 50) a = 8'($urandom_range(1, 8));
    else a = 8'($urandom);
    rgb = 24'($urandom);
    if ($urandom_range(0, 1) == 1) begin
      rgb = {8'($urandom_range(0, a)), 8'($urandom_range(0, a)), 8'($urandom_range(0, a))};
    end
    return {a, rgb};
  endfunction

  // Send one pixel transaction, with an occasional gap before it
  task automatic send_pixel(input logic [31:0] px);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    queue_pixel_words(px);
    pixels_sent++;
  endtask

  // Hold off input until every expected word is out, then let the pipeline go quiet
  task automatic settle_words();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One config transaction; mirror it into the predictor once accepted
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_WIDTH:  img_w = val;
      CFG_HEIGHT: img_h = val;
      CFG_PREMUL: premul_on = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic pm);
    settle_words();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_PREMUL, {{(DIM_W-1){1'b0}}, pm});
  endtask

  // Reset geometry is 1x1 straight alpha: every pixel is a full image
  task automatic test_reset_defaults();
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0000_0000);
    send_pixel(32'h00ab_cdef);
  endtask

  // Zero and oversize dimensions, and shrinking the image mid-frame
  task automatic test_dimension_clamp();
    set_image(13'd0, 13'd0, 1'b0);
    send_pixel(32'h8040_2010);
    set_image(13'h1fff, 13'd4097, 1'b0);
    send_pixel(32'h1234_5678);
    send_pixel(32'h9abc_def0);
    set_image(13'd1, 13'd1, 1'b0);
    send_pixel(32'h5555_aaaa);
    send_pixel(32'haaaa_5555);
    set_image(13'd4096, 13'd1, 1'b0);
    send_pixel(32'h0f0f_f0f0);
    set_image(13'd1, 13'd1, 1'b0);
    send_pixel(32'hf0f0_0f0f);
  endtask

  // Clear alpha, opaque bypass, saturation and rounding of the divide
  task automatic test_unpremultiply();
    set_image(13'd4, 13'd2, 1'b1);
    send_pixel(32'h00ff_8001);
    send_pixel(32'hff12_3456);
    send_pixel(32'h01ff_0100);
    send_pixel(32'h80c8_407f);
    send_pixel(32'h0201_0200);
    send_pixel(32'hfefe_fd00);
    send_pixel(32'h7f7f_3f00);
    send_pixel(32'h0302_0103);
  endtask

  // A write to the unmapped index must leave the geometry alone
  task automatic test_spare_register();
    settle_words();
    write_reg(CFG_SPARE, 13'h1fff);
    send_pixel(32'hc0ff_ee00);
  endtask

  // Mostly whole small images with random content, some huge headers cut short
  task automatic test_random_images();
    int w;
    int h;
    int n;
    while (pixels_sent < PIXEL_TARGET) begin
      quiet = (pixels_sent >= 90 && pixels_sent < 140);
      if ($urandom_range(0, 99) < 15) begin
        set_image(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                  1'($urandom_range(0, 1)));
        n = $urandom_range(1, 4);
      end else begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 4);
        set_image(13'(w), 13'(h), 1'($urandom_range(0, 1)));
        n = w * h * $urandom_range(1, 2);
      end
      repeat (n) send_pixel(random_argb());
    end
    quiet = 1'b0;
  endtask

  // Compare each output transaction with the oldest expected word
  always @(posedge clk) begin : check_words
    bmp_word_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (words_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("tb_top: unexpected output word %h user=%0b last=%0b",
                   out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        due = words_due.pop_front();
        if (out_tdata[31:0] !== due.word || out_tdata[34:32] !== due.nbytes ||
            out_tdata[35] !== due.eoi || out_tuser !== due.hdr || out_tlast !== due.last) begin
          if (mismatches < MAX_REPORTS)
            $display("tb_top: want %h n=%0d h=%0b l=%0b e=%0b, got %h n=%0d h=%0b l=%0b e=%0b",
                     due.word, due.nbytes, due.hdr, due.last, due.eoi,
                     out_tdata[31:0], out_tdata[34:32], out_tuser, out_tlast, out_tdata[35]);
          mismatches++;
        end
      end
    end
  end

  // Hard stop if the run hangs
  initial begin
    #4_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_WIDTH;
    cfg_data    = '0;
    quiet       = 1'b0;
    img_w       = 13'd1;
    img_h       = 13'd1;
    premul_on   = 1'b0;
    pix_done    = '0;
    pixels_sent = 0;
    mismatches  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_dimension_clamp();
    test_unpremultiply();
    test_spare_register();
    test_random_images();
    settle_words();

    if (mismatches == 0 && words_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
